[hdl/gpq_pkg.sv]
// ============================================================================
// gpq_pkg
// Shared types, codes and constants of the gated packet queue.
// ============================================================================
package gpq_pkg;

    localparam int QUEUE_DEPTH       = 16;
    localparam int MAX_PAYLOAD_BYTES = 8;
    localparam int PTR_W             = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W           = 5;
    localparam int NUM_COUNTERS      = 9;
    localparam int CNT_IDX_W         = 4;
    localparam int CNT_W             = 32;

    localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd50;

    // request functions
    localparam logic [2:0] FN_ENQUEUE = 3'd0;
    localparam logic [2:0] FN_HOST    = 3'd1;
    localparam logic [2:0] FN_TICK    = 3'd2;
    localparam logic [2:0] FN_POP     = 3'd3;
    localparam logic [2:0] FN_SEND    = 3'd4;
    localparam logic [2:0] FN_KEY     = 3'd5;
    localparam logic [2:0] FN_STAT    = 3'd6;

    // result status codes
    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_QUEUED    = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_LONG      = 3'd3;
    localparam logic [2:0] ST_DELIVERED = 3'd4;
    localparam logic [2:0] ST_HELD      = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_VIDEO_CTRL = 2'd0;
    localparam logic [1:0] CFG_VIDEO_DATA = 2'd1;
    localparam logic [1:0] CFG_FRAME_MARK = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT    = 2'd3;

    typedef logic [CNT_IDX_W-1:0] t_cnt_idx;

    // event counter indexes
    localparam t_cnt_idx C_SEEN    = 4'd0;
    localparam t_cnt_idx C_QUEUED  = 4'd1;
    localparam t_cnt_idx C_DROPPED = 4'd2;
    localparam t_cnt_idx C_SENT    = 4'd3;
    localparam t_cnt_idx C_FAILED  = 4'd4;
    localparam t_cnt_idx C_HELD    = 4'd5;
    localparam t_cnt_idx C_ENTER   = 4'd6;
    localparam t_cnt_idx C_FRAME   = 4'd7;
    localparam t_cnt_idx C_TIMEOUT = 4'd8;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  pkt_type;
        logic [7:0]  pkt_length;
        logic [63:0] pkt_payload;
        logic        send_ok;
        logic [3:0]  stat_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         out_type;
        logic [3:0]         out_length;
        logic [63:0]        out_payload;
        logic               busy_mode;
        logic [LEVEL_W-1:0] queue_level;
        logic [LEVEL_W-1:0] peak_level;
        logic [CNT_W-1:0]   stat_value;
    } t_out_item;

    typedef struct packed {
        logic             en;
        t_cnt_idx         idx;
        logic [CNT_W-1:0] data;
    } t_cnt_wr;

    // Keep the low len bytes of a payload, zero the rest.
    function automatic logic [63:0] byte_mask(input logic [7:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (8'(b) < len) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

[hdl/gpq_counters.sv]
// ============================================================================
// gpq_counters
// Event counter memory: one registered read port, one write port, and a
// valid bit per entry so that entries read as zero until first written.
// ============================================================================
module gpq_counters (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  gpq_pkg::t_cnt_idx      i_rd_addr,
    output logic [gpq_pkg::CNT_W-1:0] o_rd_data,
    input  gpq_pkg::t_cnt_wr       i_wr
);
    import gpq_pkg::*;

    logic [CNT_W-1:0]        mem [0:NUM_COUNTERS-1];
    logic [NUM_COUNTERS-1:0] r_valid;
    logic [CNT_W-1:0]        r_rd_data;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.idx] <= i_wr.data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.idx] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

[hdl/gated_packet_queue.sv]
// ============================================================================
// gated_packet_queue
// Bounded packet FIFO with drop-on-full, length reject, peak level, a video
// traffic gate on dequeue and memory-held event counters.
// ============================================================================
// Usage:
//   Requests enter on i_valid/o_ready carrying a t_in_item; each request
//   returns exactly one t_out_item on o_valid/i_ready. Configuration
//   registers (video codes, frame mark, idle timeout) are written through
//   i_cfg_valid/o_cfg_ready with an index and data; write them only while
//   no request is in flight.
//   Decisions are registered at acceptance, the result in the execute state.
//   A new request waits for the execute state and, for a pop that both counts
//   a new hold and times the gate out, a second counter bump state to pass.
//   Every event counter update is a read-modify-write through the single read
//   port of the counter memory (read at acceptance, written back in execute).
//   Packet slots sit in a 16 entry memory with a registered head read. The
//   next request is taken in the cycle the pending result is taken, so a
//   stalled receiver holds the result register and stops new requests.
//   Reset (synchronous, active low) empties the queue, opens the gate,
//   restores the default timeout and zeroes all counters at once; slot
//   contents stay undefined and no clearing pass is needed.
// ============================================================================
module gated_packet_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  gpq_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output gpq_pkg::t_out_item o_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import gpq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_BUMP2
    } t_state;

    typedef struct packed {
        logic [7:0]  ptype;
        logic [3:0]  len;
        logic [63:0] payload;
    } t_slot;

    // decisions taken at acceptance, finished in S_EXEC (second bump: S_BUMP2)
    typedef struct packed {
        logic [2:0]         status;
        logic               deliver;
        logic               bump;
        t_cnt_idx           bump_idx;
        logic               second;
        logic               stat_rd;
        logic               busy;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] peak;
    } t_op;

    // configuration
    logic [7:0]  r_video_ctrl;
    logic [7:0]  r_video_data;
    logic [7:0]  r_frame_mark;
    logic [15:0] r_timeout;

    // control state
    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [LEVEL_W-1:0] r_fill, n_fill;
    logic [LEVEL_W-1:0] r_peak, n_peak;
    logic               r_busy, n_busy;
    logic [15:0]        r_idle, n_idle;
    logic               r_hold, n_hold;
    t_op                r_op, n_op;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    // memories and their ports
    t_slot            slot_mem [0:QUEUE_DEPTH-1];
    t_slot            r_slot_rd;
    logic             slot_we;
    t_slot            slot_wdata;
    t_cnt_idx         dec_rd_idx;
    t_cnt_idx         cnt_rd_addr;
    logic [CNT_W-1:0] cnt_rd_data;
    t_cnt_wr          cnt_wr;

    logic accept;
    logic video_hit;
    logic frame_hit;
    logic timed_out;

    assign accept      = i_valid && o_ready;
    assign o_ready     = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign o_valid     = r_out_valid;
    assign o_item      = r_out;
    assign o_cfg_ready = 1'b1;

    assign video_hit = (i_item.pkt_type == r_video_ctrl) || (i_item.pkt_type == r_video_data);
    assign frame_hit = (i_item.pkt_type == r_frame_mark);
    assign timed_out = (r_idle >= r_timeout);

    // Configuration writes; each of the four indexes names a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_ctrl <= '0;
            r_video_data <= '0;
            r_frame_mark <= '0;
            r_timeout    <= IDLE_TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VIDEO_CTRL: r_video_ctrl <= i_cfg_data[7:0];
                CFG_VIDEO_DATA: r_video_data <= i_cfg_data[7:0];
                CFG_FRAME_MARK: r_frame_mark <= i_cfg_data[7:0];
                CFG_TIMEOUT:    r_timeout    <= i_cfg_data;
            endcase
        end
    end

    // Decode the request against current state; everything but the memory
    // data is settled here and committed at the accept edge.
    always_comb begin
        n_wr_ptr   = r_wr_ptr;
        n_rd_ptr   = r_rd_ptr;
        n_fill     = r_fill;
        n_peak     = r_peak;
        n_busy     = r_busy;
        n_idle     = r_idle;
        n_hold     = r_hold;
        slot_we    = 1'b0;
        slot_wdata = '{ptype:   i_item.pkt_type,
                        len:    i_item.pkt_length[3:0],
                        payload: i_item.pkt_payload & byte_mask(i_item.pkt_length)};
        n_op       = '0;
        n_op.status = ST_DONE;

        unique case (i_item.func)
            FN_ENQUEUE: begin
                if (i_item.pkt_length > 8'(MAX_PAYLOAD_BYTES)) begin
                    n_op.status = ST_LONG;
                end else if (r_fill == LEVEL_W'(QUEUE_DEPTH)) begin
                    n_op.status   = ST_DROPPED;
                    n_op.bump     = 1'b1;
                    n_op.bump_idx = C_DROPPED;
                end else begin
                    slot_we       = 1'b1;
                    n_wr_ptr      = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                          : r_wr_ptr + 1'b1;
                    n_fill        = r_fill + 1'b1;
                    n_peak        = (n_fill > r_peak) ? n_fill : r_peak;
                    n_op.status   = ST_QUEUED;
                    n_op.bump     = 1'b1;
                    n_op.bump_idx = C_QUEUED;
                end
            end
            FN_HOST: begin
                if (video_hit) begin
                    n_op.bump     = !r_busy;
                    n_op.bump_idx = C_ENTER;
                    n_busy        = 1'b1;
                    n_idle        = '0;
                end else if (frame_hit) begin
                    n_op.bump     = 1'b1;
                    n_op.bump_idx = C_FRAME;
                    if (r_busy) begin
                        n_busy = 1'b0;
                        n_hold = 1'b0;
                    end
                end
            end
            FN_TICK: begin
                if (r_idle != 16'hFFFF) begin
                    n_idle = r_idle + 1'b1;
                end
            end
            FN_POP: begin
                if (r_fill == '0) begin
                    n_op.status = ST_EMPTY;
                end else begin
                    n_op.deliver = 1'b1;
                    if (r_busy) begin
                        if (!r_hold) begin
                            n_op.bump     = 1'b1;
                            n_op.bump_idx = C_HELD;
                            n_op.second   = timed_out;
                            n_hold        = 1'b1;
                        end else if (timed_out) begin
                            n_op.bump     = 1'b1;
                            n_op.bump_idx = C_TIMEOUT;
                        end
                        if (timed_out) begin
                            n_busy = 1'b0;
                        end else begin
                            n_op.deliver = 1'b0;
                            n_op.status  = ST_HELD;
                        end
                    end
                    if (n_op.deliver) begin
                        n_rd_ptr    = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                            : r_rd_ptr + 1'b1;
                        n_fill      = r_fill - 1'b1;
                        n_hold      = 1'b0;
                        n_op.status = ST_DELIVERED;
                    end
                end
            end
            FN_SEND: begin
                n_op.bump     = 1'b1;
                n_op.bump_idx = i_item.send_ok ? C_SENT : C_FAILED;
            end
            FN_KEY: begin
                n_op.bump     = 1'b1;
                n_op.bump_idx = C_SEEN;
            end
            FN_STAT: begin
                n_op.stat_rd = (i_item.stat_index < CNT_IDX_W'(NUM_COUNTERS));
            end
            default: begin
                n_op.status = ST_DONE;
            end
        endcase

        n_op.busy  = n_busy;
        n_op.level = n_fill;
        n_op.peak  = n_peak;
        dec_rd_idx = n_op.stat_rd ? i_item.stat_index : n_op.bump_idx;
    end

    // Counter port steering: read the primary counter at acceptance, the
    // timeout counter during execute when a second bump follows.
    always_comb begin
        cnt_rd_addr = dec_rd_idx;
        cnt_wr      = '0;
        unique case (r_state)
            S_IDLE: begin
                cnt_rd_addr = dec_rd_idx;
            end
            S_EXEC: begin
                cnt_rd_addr = C_TIMEOUT;
                cnt_wr.en   = r_op.bump;
                cnt_wr.idx  = r_op.bump_idx;
                cnt_wr.data = cnt_rd_data + 1'b1;
            end
            S_BUMP2: begin
                cnt_rd_addr = C_TIMEOUT;
                cnt_wr.en   = 1'b1;
                cnt_wr.idx  = C_TIMEOUT;
                cnt_wr.data = cnt_rd_data + 1'b1;
            end
        endcase
    end

    // Next state and result register.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state           = r_op.second ? S_BUMP2 : S_IDLE;
                n_out_valid       = 1'b1;
                n_out.status      = r_op.status;
                n_out.out_type    = r_op.deliver ? r_slot_rd.ptype : '0;
                n_out.out_length  = r_op.deliver ? r_slot_rd.len : '0;
                n_out.out_payload = r_op.deliver ? r_slot_rd.payload : '0;
                n_out.busy_mode   = r_op.busy;
                n_out.queue_level = r_op.level;
                n_out.peak_level  = r_op.peak;
                n_out.stat_value  = r_op.stat_rd ? cnt_rd_data : '0;
            end
            S_BUMP2: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_fill      <= '0;
            r_peak      <= '0;
            r_busy      <= 1'b0;
            r_idle      <= '0;
            r_hold      <= 1'b0;
            r_op        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_wr_ptr <= n_wr_ptr;
                r_rd_ptr <= n_rd_ptr;
                r_fill   <= n_fill;
                r_peak   <= n_peak;
                r_busy   <= n_busy;
                r_idle   <= n_idle;
                r_hold   <= n_hold;
                r_op     <= n_op;
            end
        end
    end

    // Result payload carries no reset.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Slot memory: write on enqueue, read the head every cycle so the head
    // entry is registered by the accept edge of a pop.
    always_ff @(posedge i_clk) begin
        if (accept && slot_we) begin
            slot_mem[r_wr_ptr] <= slot_wdata;
        end
        r_slot_rd <= slot_mem[r_rd_ptr];
    end

    gpq_counters u_counters (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (cnt_rd_addr),
        .o_rd_data (cnt_rd_data),
        .i_wr      (cnt_wr)
    );

endmodule

[hdl/gpq_checker.sv]
// ============================================================================
// gpq_checker
// Port-level checks of the gated packet queue, bound to the top level.
// ============================================================================
module gpq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input gpq_pkg::t_out_item o_item
);
    import gpq_pkg::*;

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("stalled result changed");

    // peak never below level
    a_peak_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.peak_level >= o_item.queue_level)
        else $error("peak level below queue level");

    // held pop leaves the gate busy with packets waiting
    a_held_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status == ST_HELD |-> o_item.busy_mode && o_item.queue_level != '0)
        else $error("held without busy gate or queued packet");

    // packet fields are zero unless delivered
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status != ST_DELIVERED |->
            o_item.out_type == '0 && o_item.out_length == '0 && o_item.out_payload == '0)
        else $error("packet fields set without delivery");

endmodule

bind gated_packet_queue gpq_checker u_gpq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_item  (o_item)
);

[test/tb_top.sv]
// ============================================================================
// tb_top
// Self-checking bench for the gated packet queue. A clocked driver feeds
// requests from a backlog that the stimulus process fills. A clocked monitor
// takes the replies and compares every field against an in-bench model of
// the ring FIFO, the video gate and the event counters. Both sides idle at
// random, and the receiver holds off once for a long stretch.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gpq_pkg::*;

    localparam int LONG_HOLD   = 400;  // receiver hold-off, cycles

    // ------------------------------------------------------------------------
    // Clock, reset and DUT connections. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    t_in_item    i_item      = '0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    t_out_item   o_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    gated_packet_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------------
    t_in_item  request_backlog[$];    // requests not yet offered
    t_out_item predicted_replies[$];  // replies owed by the DUT, oldest first
    int        requests_built = 0;
    int        requests_taken = 0;
    int        mismatch_count = 0;

    bit        pace_on   = 1'b1;      // random idling on both sides
    bit        stall_req = 1'b0;      // toggle to ask for a long hold-off
    bit        stall_ack = 1'b0;
    int        hold_left = 0;
    int        tx_gap    = 0;
    int        rx_gap    = 0;
    bit        offering;
    t_out_item want_item;

    // ------------------------------------------------------------------------
    // Model state: gate configuration, packet ring, gate and counters
    // ------------------------------------------------------------------------
    logic [7:0]  code_vctrl    = 8'd0;
    logic [7:0]  code_vdata    = 8'd0;
    logic [7:0]  code_frame    = 8'd0;
    logic [15:0] timeout_ticks = IDLE_TIMEOUT_RESET;

    logic [63:0] ring_payload [QUEUE_DEPTH];
    logic [7:0]  ring_type    [QUEUE_DEPTH];
    logic [3:0]  ring_len     [QUEUE_DEPTH];
    int          wr_slot   = 0;
    int          rd_slot   = 0;
    int          fill_cnt  = 0;
    int          fill_peak = 0;
    bit          gate_busy = 1'b0;
    logic [15:0] idle_ticks = 16'd0;
    bit          hold_seen  = 1'b0;
    logic [CNT_W-1:0] evt_cnt [NUM_COUNTERS] = '{default: '0};

    function automatic void bump_event(input t_cnt_idx k);
        evt_cnt[k] = evt_cnt[k] + 1'b1;  // wraps at 32 bits
    endfunction

    // Advance the model by one request and return the reply it owes.
    function automatic t_out_item gate_queue_step(input t_in_item req);
        t_out_item res;
        bit        deliver;
        res = '0;
        res.status = ST_DONE;
        case (req.func)
            FN_ENQUEUE: begin
                if (req.pkt_length > MAX_PAYLOAD_BYTES) begin
                    res.status = ST_LONG;  // reject, touch nothing
                end else if (fill_cnt >= QUEUE_DEPTH) begin
                    bump_event(C_DROPPED);
                    res.status = ST_DROPPED;
                end else begin
                    // keep only the low pkt_length bytes
                    ring_payload[wr_slot] = '0;
                    for (int b = 0; b < MAX_PAYLOAD_BYTES; b++) begin
                        if (b < req.pkt_length) begin
                            ring_payload[wr_slot][b*8 +: 8] = req.pkt_payload[b*8 +: 8];
                        end
                    end
                    ring_type[wr_slot] = req.pkt_type;
                    ring_len[wr_slot]  = req.pkt_length[3:0];
                    wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
                    fill_cnt++;
                    bump_event(C_QUEUED);
                    if (fill_cnt > fill_peak) begin
                        fill_peak = fill_cnt;
                    end
                    res.status = ST_QUEUED;
                end
            end
            FN_HOST: begin
                // a video code wins over the frame mark when both match
                if (req.pkt_type == code_vctrl || req.pkt_type == code_vdata) begin
                    if (!gate_busy) begin
                        bump_event(C_ENTER);
                    end
                    gate_busy  = 1'b1;
                    idle_ticks = '0;
                end else if (req.pkt_type == code_frame) begin
                    bump_event(C_FRAME);
                    if (gate_busy) begin
                        gate_busy = 1'b0;
                        hold_seen = 1'b0;
                    end
                end
            end
            FN_TICK: begin
                if (idle_ticks != 16'hFFFF) begin
                    idle_ticks++;
                end
            end
            FN_POP: begin
                if (fill_cnt == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    deliver = 1'b1;
                    if (gate_busy) begin
                        // count the hold once per wait
                        if (!hold_seen) begin
                            bump_event(C_HELD);
                            hold_seen = 1'b1;
                        end
                        if (idle_ticks >= timeout_ticks) begin
                            gate_busy = 1'b0;
                            bump_event(C_TIMEOUT);
                        end else begin
                            res.status = ST_HELD;
                            deliver = 1'b0;
                        end
                    end
                    if (deliver) begin
                        res.out_type    = ring_type[rd_slot];
                        res.out_length  = ring_len[rd_slot];
                        res.out_payload = ring_payload[rd_slot];
                        rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
                        fill_cnt--;
                        hold_seen  = 1'b0;
                        res.status = ST_DELIVERED;
                    end
                end
            end
            FN_SEND: bump_event(req.send_ok ? C_SENT : C_FAILED);
            FN_KEY:  bump_event(C_SEEN);
            FN_STAT: begin
                if (req.stat_index < NUM_COUNTERS) begin
                    res.stat_value = evt_cnt[req.stat_index];
                end
            end
            default: ;  // unused function code: done, no effect
        endcase
        res.busy_mode   = gate_busy;
        res.queue_level = LEVEL_W'(fill_cnt);
        res.peak_level  = LEVEL_W'(fill_peak);
        return res;
    endfunction

    function automatic int draw_gap();
        return pace_on ? int'($urandom_range(0, 4)) : 0;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer requests from the backlog, predict on acceptance.
    // Valid stays high with a new payload when no gap is drawn, so it only
    // ever gets one nonblocking update per edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            offering = i_valid;
            if (i_valid && o_ready) begin
                predicted_replies.push_back(gate_queue_step(i_item));
                requests_taken++;
                tx_gap   = draw_gap();
                offering = 1'b0;
            end
            if (!offering) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (request_backlog.size() != 0) begin
                    i_valid <= 1'b1;
                    i_item  <= request_backlog.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: take replies, compare against the oldest prediction.
    // ------------------------------------------------------------------------
    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (predicted_replies.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: reply with none expected: %p", $time, o_item);
                end else begin
                    want_item = predicted_replies.pop_front();
                    check_field("status", 64'(want_item.status), 64'(o_item.status));
                    check_field("out_type", 64'(want_item.out_type),
                                64'(o_item.out_type));
                    check_field("out_length", 64'(want_item.out_length),
                                64'(o_item.out_length));
                    check_field("out_payload", want_item.out_payload, o_item.out_payload);
                    check_field("busy_mode", 64'(want_item.busy_mode),
                                64'(o_item.busy_mode));
                    check_field("queue_level", 64'(want_item.queue_level),
                                64'(o_item.queue_level));
                    check_field("peak_level", 64'(want_item.peak_level),
                                64'(o_item.peak_level));
                    check_field("stat_value", 64'(want_item.stat_value),
                                64'(o_item.stat_value));
                end
                rx_gap = draw_gap();
            end else if (rx_gap != 0) begin
                rx_gap--;
            end
            // long hold-off on request, counted here
            if (stall_req != stall_ack) begin
                stall_ack = stall_req;
                hold_left = LONG_HOLD;
            end else if (hold_left != 0) begin
                hold_left--;
            end
            i_ready <= (rx_gap == 0) && (hold_left == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Randomize every field, then fix the function.
    function automatic t_in_item random_request(input logic [2:0] fn);
        t_in_item r;
        r.func        = fn;
        r.pkt_type    = 8'($urandom_range(0, 255));
        r.pkt_length  = 8'($urandom_range(0, 255));
        r.pkt_payload = ($urandom_range(0, 7) == 0) ? '1 : {$urandom, $urandom};
        r.send_ok     = 1'($urandom_range(0, 1));
        r.stat_index  = 4'($urandom_range(0, 15));
        return r;
    endfunction

    // Mostly legal lengths, now and then an over-length one.
    function automatic t_in_item enqueue_request();
        t_in_item r;
        r = random_request(FN_ENQUEUE);
        if ($urandom_range(0, 9) != 0) begin
            r.pkt_length = 8'($urandom_range(0, MAX_PAYLOAD_BYTES));
        end else begin
            r.pkt_length = 8'($urandom_range(MAX_PAYLOAD_BYTES + 1, 255));
        end
        return r;
    endfunction

    function automatic t_in_item host_request(input logic [7:0] ptype);
        t_in_item r;
        r = random_request(FN_HOST);
        r.pkt_type = ptype;
        return r;
    endfunction

    task automatic offer(input t_in_item r);
        request_backlog.push_back(r);
        requests_built++;
    endtask

    task automatic offer_pops(input int n);
        repeat (n) offer(random_request(FN_POP));
    endtask

    // Mix of fill bursts, video episodes, drains and loose noise.
    task automatic build_traffic(input int count);
        int start;
        int roll;
        int ticks;
        start = requests_built;
        while (requests_built - start < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                repeat ($urandom_range(4, 20)) offer(enqueue_request());
            end else if (roll < 55) begin
                // enter busy, wait out part or all of the timeout, maybe end
                // the frame, and pop along the way
                offer(host_request($urandom_range(0, 1) ? code_vctrl : code_vdata));
                offer_pops($urandom_range(0, 2));
                ticks = (timeout_ticks < 24) ? int'(timeout_ticks) + 2 : 24;
                repeat ($urandom_range(0, ticks)) offer(random_request(FN_TICK));
                offer_pops($urandom_range(1, 3));
                if ($urandom_range(0, 1) != 0) begin
                    offer(host_request(code_frame));
                end
                offer_pops($urandom_range(0, 2));
            end else if (roll < 75) begin
                offer_pops($urandom_range(1, 10));
            end else begin
                offer(random_request(3'($urandom_range(0, 7))));
            end
        end
    endtask

    // Sample at the falling edge so the clocked processes have settled.
    task automatic wait_all_answered();
        do @(negedge i_clk);
        while (request_backlog.size() != 0 || i_valid || predicted_replies.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_VIDEO_CTRL: code_vctrl    = val[7:0];
            CFG_VIDEO_DATA: code_vdata    = val[7:0];
            CFG_FRAME_MARK: code_frame    = val[7:0];
            CFG_TIMEOUT:    timeout_ticks = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_gate(input logic [7:0] vctrl, input logic [7:0] vdata,
                                input logic [7:0] frame, input logic [15:0] tmo);
        write_reg(CFG_VIDEO_CTRL, {8'h00, vctrl});
        write_reg(CFG_VIDEO_DATA, {8'h00, vdata});
        write_reg(CFG_FRAME_MARK, {8'h00, frame});
        write_reg(CFG_TIMEOUT, tmo);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        t_in_item r;
        int       mark;
        logic [7:0] code_a;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: all codes zero, so type 0 is a video write even
        // though it also matches the frame mark.
        offer(random_request(FN_POP));               // empty queue
        r = random_request(FN_ENQUEUE);
        r.pkt_type = 8'h00; r.pkt_length = 8'd0; r.pkt_payload = '1;
        offer(r);                                    // payload stored as zero
        r = random_request(FN_ENQUEUE);
        r.pkt_type = 8'hFF; r.pkt_length = 8'd8; r.pkt_payload = '1;
        offer(r);
        r.pkt_length = 8'd9;   offer(r);             // one byte too long
        r.pkt_length = 8'd255; offer(r);
        r = random_request(FN_ENQUEUE);
        r.pkt_type = 8'hA5; r.pkt_length = 8'd3;
        offer(r);                                    // upper bytes dropped
        offer(host_request(8'h00));                  // collision: enter busy
        offer_pops(2);                               // held, counted once
        r = random_request(FN_STAT);
        r.stat_index = C_HELD;  offer(r);
        r.stat_index = 4'd9;    offer(r);
        r.stat_index = 4'd15;   offer(r);
        offer(random_request(3'd7));                 // unused function
        offer(random_request(FN_KEY));
        r = random_request(FN_SEND);
        r.send_ok = 1'b1; offer(r);
        r.send_ok = 1'b0; offer(r);
        wait_all_answered();

        // Short timeout with distinct codes; the gate is still busy here.
        program_gate(8'h10, 8'h20, 8'h30, 16'd2);
        offer(random_request(FN_TICK));
        offer(random_request(FN_POP));               // still held
        offer(random_request(FN_TICK));
        offer(random_request(FN_POP));               // times out, delivers
        offer(host_request(8'h30));                  // frame mark while open
        offer(host_request(8'h20));
        offer(host_request(8'h30));                  // frame mark ends busy
        offer(random_request(FN_POP));
        r = random_request(FN_STAT);
        r.stat_index = C_TIMEOUT; offer(r);
        r.stat_index = C_FRAME;   offer(r);

        // Random phases over a spread of settings, extremes included.
        for (int phase = 0; phase < 8; phase++) begin
            wait_all_answered();
            case (phase)
                0: program_gate(8'h00, 8'hFF, 8'h80, 16'd1);
                1: program_gate(8'hFF, 8'h00, 8'hFF, 16'd0);   // zero timeout
                2: program_gate(8'($urandom), 8'($urandom), 8'($urandom),
                                16'($urandom_range(1, 12)));
                3: begin
                    code_a = 8'($urandom);
                    program_gate(code_a, code_a, 8'($urandom), 16'hFFFF);
                end
                default: program_gate(8'($urandom), 8'($urandom), 8'($urandom),
                                      16'($urandom_range(0, 20)));
            endcase
            pace_on <= (phase != 4);                 // one stretch at full rate
            build_traffic(230);
            if (phase == 2) begin
                // hold the receiver off while the sender keeps offering
                mark = requests_taken + 40;
                while (requests_taken < mark) @(negedge i_clk);
                stall_req <= ~stall_req;
            end
        end

        wait_all_answered();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
